FILE: hw/rtl/bshu_pkg.sv
package bshu_pkg;

  localparam int LOG_BITS_DEF = 8;

  localparam int OFFS_W   = 24;
  localparam int HEIGHT_W = 32;
  localparam int RADIUS_W = 23;
  localparam int RATE_W   = 24;
  localparam int Q15_W    = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam int SQ_W   = 48;   // ax*ax and the sum of squares
  localparam int RSQ_W  = 46;   // radius squared
  localparam int RAD_W  = 62;   // square root radicand, d2 << 16
  localparam int ROOT_W = 31;   // square root result
  localparam int DIVN_W = 38;   // dividend d << 7
  localparam int ND_W   = 15;   // normalized distance
  localparam int EXP_W  = 19;   // exponent, Q4.15 up to 10.0
  localparam int MC_W   = 25;   // maximum change

  localparam logic [Q15_W-1:0] Q15_ONE = 16'h8000;

  typedef enum logic [CFG_AW-1:0] {
    CFG_RADIUS, CFG_SHAPE, CFG_FALLOFF, CFG_CURVE,
    CFG_STRENGTH, CFG_OP, CFG_TARGET, CFG_RATE
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SHAPE_CIRCLE, SHAPE_SQUARE, SHAPE_DIAMOND, SHAPE_CUSTOM
  } shape_t;

  typedef enum logic [2:0] {
    FO_LINEAR, FO_SMOOTH, FO_SHARP, FO_CONST, FO_CUSTOM
  } falloff_t;

  typedef enum logic [2:0] {
    OP_RAISE, OP_LOWER, OP_FLATTEN, OP_HOLD, OP_SET
  } hop_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [1:0]          shape;
    logic [2:0]          falloff;
    logic [Q15_W-1:0]    curve;
    logic [Q15_W-1:0]    strength;
    logic [2:0]          op;
    logic [HEIGHT_W-1:0] target;
    logic [RATE_W-1:0]   rate;
  } bshu_cfg_t;

  typedef struct packed {
    logic                hit;
    logic [HEIGHT_W-1:0] h;
  } bshu_side_t;

  function automatic logic [63:0] bshu_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = v;
    res   = '0;
    bit_w = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-idx) in Q30
  function automatic logic [29:0] bshu_root(input int idx);
    logic [63:0] x;
    x = 64'd1 << 29;
    for (int j = 1; j <= 12; j++) begin
      if (j <= idx) x = bshu_isqrt(x << 30);
    end
    return x[29:0];
  endfunction

endpackage

FILE: hw/rtl/brush_sample_height_update.sv
// Channel   Handshake                Payload
// in        in_valid / in_stall      in_offset_x, in_offset_z, in_current_height
// out       out_valid / out_stall    out_new_height, out_changed
// cfg       cfg_we                   cfg_idx, cfg_wdata
//
// One sample per cycle while in_stall is low. The pipeline depth is set by
// the one-bit-per-stage square root (31 stages) and divider (15 stages) and the
// squaring and root-product stages of the power unit.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
// A stalled result parks in a skid register; in_stall rises only while it is full.
module brush_sample_height_update #(
  parameter int LOG_TABLE_BITS = bshu_pkg::LOG_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bshu_pkg::CFG_AW-1:0]          cfg_idx,
  input  logic [bshu_pkg::CFG_DW-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [bshu_pkg::OFFS_W-1:0]   in_offset_x,
  input  logic signed [bshu_pkg::OFFS_W-1:0]   in_offset_z,
  input  logic signed [bshu_pkg::HEIGHT_W-1:0] in_current_height,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bshu_pkg::HEIGHT_W-1:0] out_new_height,
  output logic                                 out_changed
);
  import bshu_pkg::*;

  bshu_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{radius: 23'd1280, shape: SHAPE_CIRCLE, falloff: FO_SMOOTH,
                 curve: 16'd16384, strength: Q15_ONE, op: OP_RAISE,
                 target: '0, rate: 24'd10486};
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RADIUS:   cfg_r.radius   <= cfg_wdata[RADIUS_W-1:0];
        CFG_SHAPE:    cfg_r.shape    <= cfg_wdata[1:0];
        CFG_FALLOFF:  cfg_r.falloff  <= cfg_wdata[2:0];
        CFG_CURVE:    cfg_r.curve    <= cfg_wdata[Q15_W-1:0];
        CFG_STRENGTH: cfg_r.strength <= cfg_wdata[Q15_W-1:0];
        CFG_OP:       cfg_r.op       <= cfg_wdata[2:0];
        CFG_TARGET:   cfg_r.target   <= cfg_wdata[HEIGHT_W-1:0];
        CFG_RATE:     cfg_r.rate     <= cfg_wdata[RATE_W-1:0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  logic en;
  logic skid_valid_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  logic              dv;
  logic [RAD_W-1:0]  radicand;
  bshu_side_t        dside;
  logic              sv;
  logic [ROOT_W-1:0] root;
  bshu_side_t        sside;
  logic              qv;
  logic [Q15_W-1:0]  qu;
  bshu_side_t        qside;
  logic              pv_w;
  logic [Q15_W-1:0]  pw, pu;
  bshu_side_t        pside;
  logic              pv;
  logic [HEIGHT_W-1:0] pnh;
  logic              pchg;

  bshu_dist u_dist (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .valid_i(in_valid), .x_i(in_offset_x), .z_i(in_offset_z),
    .h_i($unsigned(in_current_height)),
    .valid_o(dv), .radicand_o(radicand), .side_o(dside)
  );

  bshu_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .valid_i(dv), .radicand_i(radicand), .side_i(dside),
    .valid_o(sv), .root_o(root), .side_o(sside)
  );

  bshu_div u_div (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .valid_i(sv), .d_i(root), .side_i(sside),
    .valid_o(qv), .u_o(qu), .side_o(qside)
  );

  bshu_pow #(.LOG_BITS(LOG_TABLE_BITS)) u_pow (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .valid_i(qv), .u_i(qu), .side_i(qside),
    .valid_o(pv_w), .pw_o(pw), .u_o(pu), .side_o(pside)
  );

  bshu_apply u_apply (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .valid_i(pv_w), .pw_i(pw), .u_i(pu), .side_i(pside),
    .valid_o(pv), .nh_o(pnh), .chg_o(pchg)
  );

  logic                out_valid_r;
  logic [HEIGHT_W-1:0] out_nh_r, skid_nh_r;
  logic                out_chg_r, skid_chg_r;
  logic                out_take, push;

  assign out_take = !out_valid_r || !out_stall;
  assign push     = pv && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_nh_r  <= skid_valid_r ? skid_nh_r : pnh;
      out_chg_r <= skid_valid_r ? skid_chg_r : pchg;
    end else if (push) begin
      // hold the request that arrived behind a stalled output
      skid_nh_r  <= pnh;
      skid_chg_r <= pchg;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_height = $signed(out_nh_r);
  assign out_changed    = out_chg_r;

  a_skid_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled while output was free");

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request with an empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r && out_valid_r)
    else $error("skid did not drain into the output register");

endmodule

FILE: hw/rtl/bshu_dist.sv
module bshu_dist (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  bshu_pkg::bshu_cfg_t                cfg,
  input  logic                               valid_i,
  input  logic signed [bshu_pkg::OFFS_W-1:0] x_i,
  input  logic signed [bshu_pkg::OFFS_W-1:0] z_i,
  input  logic [bshu_pkg::HEIGHT_W-1:0]      h_i,
  output logic                               valid_o,
  output logic [bshu_pkg::RAD_W-1:0]         radicand_o,
  output bshu_pkg::bshu_side_t               side_o
);
  import bshu_pkg::*;

  logic [OFFS_W-1:0]   ax_nxt, az_nxt;
  logic                v1_r, v2_r, v3_r;
  logic [OFFS_W-1:0]   ax_r, az_r;
  logic [HEIGHT_W-1:0] h1_r, h2_r;
  logic [SQ_W-1:0]     sqx_r, sqz_r;
  logic                shape_ok_nxt, shape_ok_r;
  logic [RSQ_W-1:0]    rsq_r;
  logic [SQ_W-1:0]     d2;
  logic                hit;
  logic [OFFS_W:0]     manh;
  logic [RAD_W-1:0]    radicand_r;
  bshu_side_t          side_r;

  assign ax_nxt = x_i[OFFS_W-1] ? ($unsigned(~x_i) + 24'd1) : $unsigned(x_i);
  assign az_nxt = z_i[OFFS_W-1] ? ($unsigned(~z_i) + 24'd1) : $unsigned(z_i);
  assign manh   = {1'b0, ax_r} + {1'b0, az_r};

  always_comb begin
    case (cfg.shape)
      SHAPE_SQUARE:  shape_ok_nxt = (ax_r <= {1'b0, cfg.radius}) &&
                                    (az_r <= {1'b0, cfg.radius});
      SHAPE_DIAMOND: shape_ok_nxt = manh <= {2'b0, cfg.radius};
      default:       shape_ok_nxt = 1'b1;
    endcase
  end

  assign d2  = sqx_r + sqz_r;
  assign hit = (d2 < {2'b0, rsq_r}) && shape_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // the user must keep radius static while samples are in flight; not enforced here
  always_ff @(posedge clk) begin
    rsq_r <= {23'b0, cfg.radius} * {23'b0, cfg.radius};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r        <= ax_nxt;
      az_r        <= az_nxt;
      h1_r        <= h_i;
      sqx_r       <= {24'b0, ax_r} * {24'b0, ax_r};
      sqz_r       <= {24'b0, az_r} * {24'b0, az_r};
      shape_ok_r  <= shape_ok_nxt;
      h2_r        <= h1_r;
      radicand_r  <= hit ? {d2[RSQ_W-1:0], 16'b0} : '0;
      side_r      <= '{hit: hit, h: h2_r};
    end
  end

  assign valid_o    = v3_r;
  assign radicand_o = radicand_r;
  assign side_o     = side_r;

endmodule

FILE: hw/rtl/bshu_sqrt.sv
module bshu_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic [bshu_pkg::RAD_W-1:0]  radicand_i,
  input  bshu_pkg::bshu_side_t        side_i,
  output logic                        valid_o,
  output logic [bshu_pkg::ROOT_W-1:0] root_o,
  output bshu_pkg::bshu_side_t        side_o
);
  import bshu_pkg::*;

  logic              v_a    [0:ROOT_W];
  logic [RAD_W-1:0]  rem_a  [0:ROOT_W];
  logic [ROOT_W-1:0] root_a [0:ROOT_W];
  bshu_side_t        side_a [0:ROOT_W];

  assign v_a[0]    = valid_i;
  assign rem_a[0]  = radicand_i;
  assign root_a[0] = '0;
  assign side_a[0] = side_i;

  // one result bit per stage, most significant first
  for (genvar g = 0; g < ROOT_W; g++) begin : g_bit
    localparam int K = ROOT_W - 1 - g;
    logic [63:0]       trial, diff;
    logic              ge;
    logic              v_r;
    logic [RAD_W-1:0]  rem_r;
    logic [ROOT_W-1:0] root_r;
    bshu_side_t        side_r;

    assign trial = ({33'b0, root_a[g]} << (K + 1)) | (64'd1 << (2 * K));
    assign diff  = {2'b0, rem_a[g]} - trial;
    assign ge    = {2'b0, rem_a[g]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? diff[RAD_W-1:0] : rem_a[g];
        root_r <= ge ? (root_a[g] | (31'd1 << K)) : root_a[g];
        side_r <= side_a[g];
      end
    end

    assign v_a[g+1]    = v_r;
    assign rem_a[g+1]  = rem_r;
    assign root_a[g+1] = root_r;
    assign side_a[g+1] = side_r;
  end

  assign valid_o = v_a[ROOT_W];
  assign root_o  = root_a[ROOT_W];
  assign side_o  = side_a[ROOT_W];

endmodule

FILE: hw/rtl/bshu_div.sv
module bshu_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  bshu_pkg::bshu_cfg_t           cfg,
  input  logic                          valid_i,
  input  logic [bshu_pkg::ROOT_W-1:0]   d_i,
  input  bshu_pkg::bshu_side_t          side_i,
  output logic                          valid_o,
  output logic [bshu_pkg::Q15_W-1:0]    u_o,
  output bshu_pkg::bshu_side_t          side_o
);
  import bshu_pkg::*;

  logic              v_a    [0:ND_W];
  logic [DIVN_W-1:0] rem_a  [0:ND_W];
  logic [ND_W-1:0]   q_a    [0:ND_W];
  bshu_side_t        side_a [0:ND_W];

  assign v_a[0]    = valid_i;
  assign rem_a[0]  = {d_i, 7'b0};
  assign q_a[0]    = '0;
  assign side_a[0] = side_i;

  // restoring division, one quotient bit per stage
  for (genvar g = 0; g < ND_W; g++) begin : g_bit
    localparam int K = ND_W - 1 - g;
    logic [DIVN_W-1:0] sub;
    logic              ge;
    logic              v_r;
    logic [DIVN_W-1:0] rem_r;
    logic [ND_W-1:0]   q_r;
    bshu_side_t        side_r;

    assign sub = {15'b0, cfg.radius} << K;
    assign ge  = rem_a[g] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? (rem_a[g] - sub) : rem_a[g];
        q_r    <= ge ? (q_a[g] | (15'd1 << K)) : q_a[g];
        side_r <= side_a[g];
      end
    end

    assign v_a[g+1]    = v_r;
    assign rem_a[g+1]  = rem_r;
    assign q_a[g+1]    = q_r;
    assign side_a[g+1] = side_r;
  end

  assign valid_o = v_a[ND_W];
  assign u_o     = Q15_ONE - {1'b0, q_a[ND_W]};
  assign side_o  = side_a[ND_W];

endmodule

FILE: hw/rtl/bshu_pow.sv
module bshu_pow #(
  parameter int LOG_BITS = bshu_pkg::LOG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  bshu_pkg::bshu_cfg_t        cfg,
  input  logic                       valid_i,
  input  logic [bshu_pkg::Q15_W-1:0] u_i,
  input  bshu_pkg::bshu_side_t       side_i,
  output logic                       valid_o,
  output logic [bshu_pkg::Q15_W-1:0] pw_o,
  output logic [bshu_pkg::Q15_W-1:0] u_o,
  output bshu_pkg::bshu_side_t       side_o
);
  import bshu_pkg::*;

  localparam int NW = LOG_BITS + 4;
  localparam int PW = LOG_BITS + 8;

  typedef struct packed {
    logic [Q15_W-1:0] u;
    bshu_side_t       side;
  } ptag_t;

  logic [Q15_W-1:0] c;
  logic [EXP_W-1:0] e15_nxt, e15_r;

  assign c = (cfg.curve > Q15_ONE) ? Q15_ONE : cfg.curve;

  always_comb begin
    case (cfg.falloff)
      FO_SMOOTH: e15_nxt = 19'h08000 + ({3'b0, c} + {2'b0, c, 1'b0});
      FO_SHARP:  e15_nxt = 19'h10000 + {c, 3'b0};
      default:   e15_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    e15_r <= e15_nxt;
  end

  // leading one of u and the normalized mantissa
  logic [3:0]  p_nxt;
  logic [30:0] y_nxt;

  always_comb begin
    p_nxt = '0;
    for (int j = 0; j < Q15_W; j++) begin
      if (u_i[j]) p_nxt = 4'(j);
    end
    y_nxt = {15'b0, u_i} << (5'd30 - {1'b0, p_nxt});
  end

  logic          v0_r;
  logic [30:0]   y0_r;
  logic [3:0]    p0_r;
  ptag_t         t0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y0_r <= y_nxt;
      p0_r <= p_nxt;
      t0_r <= '{u: u_i, side: side_i};
    end
  end

  // log2 fraction bits by repeated squaring
  logic                sv_a [0:LOG_BITS];
  logic [30:0]         sy_a [0:LOG_BITS];
  logic [LOG_BITS-1:0] sf_a [0:LOG_BITS];
  logic [3:0]          sp_a [0:LOG_BITS];
  ptag_t               st_a [0:LOG_BITS];

  assign sv_a[0] = v0_r;
  assign sy_a[0] = y0_r;
  assign sf_a[0] = '0;
  assign sp_a[0] = p0_r;
  assign st_a[0] = t0_r;

  for (genvar i = 0; i < LOG_BITS; i++) begin : g_sq
    logic [61:0]         sq;
    logic [31:0]         t;
    logic                v_r;
    logic [30:0]         y_r;
    logic [LOG_BITS-1:0] f_r;
    logic [3:0]          p_r;
    ptag_t               tag_r;

    assign sq = {31'b0, sy_a[i]} * {31'b0, sy_a[i]};
    assign t  = sq[61:30];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= sv_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        y_r   <= t[31] ? t[31:1] : t[30:0];
        f_r   <= {sf_a[i][LOG_BITS-2:0], t[31]};
        p_r   <= sp_a[i];
        tag_r <= st_a[i];
      end
    end

    assign sv_a[i+1] = v_r;
    assign sy_a[i+1] = y_r;
    assign sf_a[i+1] = f_r;
    assign sp_a[i+1] = p_r;
    assign st_a[i+1] = tag_r;
  end

  // scale -log2(u) by the exponent
  logic [NW-1:0]       n;
  logic [NW+EXP_W-1:0] prod;
  logic                lv_r;
  logic [PW-1:0]       pl_r;
  ptag_t               lt_r;

  assign n    = {(4'd15 - sp_a[LOG_BITS]), {LOG_BITS{1'b0}}} - {4'b0, sf_a[LOG_BITS]};
  assign prod = {{EXP_W{1'b0}}, n} * {{NW{1'b0}}, e15_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else if (en) begin
      lv_r <= sv_a[LOG_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= prod[NW+EXP_W-1:15];
      lt_r <= st_a[LOG_BITS];
    end
  end

  // 2^-frac as a product of fixed roots
  logic                rv_a  [0:LOG_BITS];
  logic [30:0]         val_a [0:LOG_BITS];
  logic [7:0]          rq_a  [0:LOG_BITS];
  logic [LOG_BITS-1:0] rr_a  [0:LOG_BITS];
  ptag_t               rt_a  [0:LOG_BITS];

  assign rv_a[0]  = lv_r;
  assign val_a[0] = 31'h4000_0000;
  assign rq_a[0]  = pl_r[PW-1:LOG_BITS];
  assign rr_a[0]  = pl_r[LOG_BITS-1:0];
  assign rt_a[0]  = lt_r;

  for (genvar i = 1; i <= LOG_BITS; i++) begin : g_root
    localparam logic [29:0] RT = bshu_root(i);
    logic [60:0]         mp;
    logic                v_r;
    logic [30:0]         val_r;
    logic [7:0]          q_r;
    logic [LOG_BITS-1:0] r_r;
    ptag_t               tag_r;

    assign mp = {30'b0, val_a[i-1]} * {31'b0, RT};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= rv_a[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r <= rr_a[i-1][LOG_BITS-i] ? mp[60:30] : val_a[i-1];
        q_r   <= rq_a[i-1];
        r_r   <= rr_a[i-1];
        tag_r <= rt_a[i-1];
      end
    end

    assign rv_a[i]  = v_r;
    assign val_a[i] = val_r;
    assign rq_a[i]  = q_r;
    assign rr_a[i]  = r_r;
    assign rt_a[i]  = tag_r;
  end

  // shift out the integer part of the exponent
  logic [4:0]       sh;
  logic [30:0]      shifted;
  logic             fv_r;
  logic [Q15_W-1:0] pw_r;
  ptag_t            ft_r;

  assign sh      = 5'd15 + {1'b0, rq_a[LOG_BITS][3:0]};
  assign shifted = val_a[LOG_BITS] >> sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= rv_a[LOG_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw_r <= (rq_a[LOG_BITS][7:4] != 4'd0) ? '0 : shifted[Q15_W-1:0];
      ft_r <= rt_a[LOG_BITS];
    end
  end

  assign valid_o = fv_r;
  assign pw_o    = pw_r;
  assign u_o     = ft_r.u;
  assign side_o  = ft_r.side;

endmodule

FILE: hw/rtl/bshu_apply.sv
module bshu_apply (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  bshu_pkg::bshu_cfg_t           cfg,
  input  logic                          valid_i,
  input  logic [bshu_pkg::Q15_W-1:0]    pw_i,
  input  logic [bshu_pkg::Q15_W-1:0]    u_i,
  input  bshu_pkg::bshu_side_t          side_i,
  output logic                          valid_o,
  output logic [bshu_pkg::HEIGHT_W-1:0] nh_o,
  output logic                          chg_o
);
  import bshu_pkg::*;

  logic [Q15_W-1:0] fo, s;
  logic [31:0]      wprod;

  assign s = (cfg.strength > Q15_ONE) ? Q15_ONE : cfg.strength;

  always_comb begin
    case (cfg.falloff)
      FO_SMOOTH, FO_SHARP: fo = pw_i;
      FO_CONST:            fo = Q15_ONE;
      default:             fo = u_i;
    endcase
  end

  assign wprod = {16'b0, fo} * {16'b0, s};

  logic                v1_r, v2_r, v3_r, v4_r;
  logic [Q15_W-1:0]    w_r;
  logic [HEIGHT_W-1:0] h1_r, h2_r, h3_r;
  logic [MC_W-1:0]     mc_r;
  logic                chg2_r, chg3_r, chg4_r;
  logic [39:0]         mprod;

  assign mprod = {24'b0, w_r} * {16'b0, cfg.rate};

  // stage 3: saturating sums and the flatten step
  logic [33:0]         up, dn;
  logic [32:0]         diff, ad, mc_ext, step;
  logic [HEIGHT_W-1:0] up_sat, dn_sat;
  logic [HEIGHT_W-1:0] up_r, dn_r, step_r;
  logic                neg_r;

  assign up     = {{2{h2_r[31]}}, h2_r} + {9'b0, mc_r};
  assign dn     = {{2{h2_r[31]}}, h2_r} - {9'b0, mc_r};
  assign diff   = {cfg.target[31], cfg.target} - {h2_r[31], h2_r};
  assign ad     = diff[32] ? (~diff + 33'd1) : diff;
  assign mc_ext = {8'b0, mc_r};
  assign step   = (ad < mc_ext) ? ad : mc_ext;

  always_comb begin
    if (up[33:31] == 3'b000 || up[33:31] == 3'b111) up_sat = up[31:0];
    else up_sat = up[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (dn[33:31] == 3'b000 || dn[33:31] == 3'b111) dn_sat = dn[31:0];
    else dn_sat = dn[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  // stage 4: pick the result
  logic [HEIGHT_W-1:0] nh_nxt, nh_r;

  always_comb begin
    if (!chg3_r) begin
      nh_nxt = h3_r;
    end else begin
      case (cfg.op)
        OP_RAISE:   nh_nxt = up_r;
        OP_LOWER:   nh_nxt = dn_r;
        OP_FLATTEN: nh_nxt = neg_r ? (h3_r - step_r) : (h3_r + step_r);
        OP_SET:     nh_nxt = cfg.target;
        default:    nh_nxt = h3_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r    <= side_i.hit ? wprod[30:15] : '0;
      h1_r   <= side_i.h;
      mc_r   <= mprod[39:15];
      chg2_r <= (w_r != '0) && (cfg.op <= OP_SET);
      h2_r   <= h1_r;
      up_r   <= up_sat;
      dn_r   <= dn_sat;
      step_r <= step[31:0];
      neg_r  <= diff[32];
      chg3_r <= chg2_r;
      h3_r   <= h2_r;
      nh_r   <= nh_nxt;
      chg4_r <= chg3_r;
    end
  end

  assign valid_o = v4_r;
  assign nh_o    = nh_r;
  assign chg_o   = chg4_r;

endmodule
